/* rtl/urlpd_pkg.sv */
// Shared types, character constants and hex helpers for the URL percent decoder.
// Has no dependencies; every other file of the decoder imports it.
`default_nettype none

package urlpd_pkg;

   // Default number of decoded-byte groups held between the front and back halves.
   localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

   // Characters with a meaning in the encoding.
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   // Value of the first letter digit.
   localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

   // Escape tracking: nothing pending, a percent seen, a percent and one digit seen.
   typedef enum logic [1:0] {
      ESC_IDLE  = 2'd0,
      ESC_PCT   = 2'd1,
      ESC_DIGIT = 2'd2
   } esc_mode_type;

   // All decoded bytes caused by one input transaction, oldest in bytes[0].
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            last;
   } group_type;

   function automatic logic hex_valid(input logic [7:0] b);
      hex_valid = ((b >= CHAR_ZERO) && (b <= CHAR_NINE)) ||
                  ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_F)) ||
                  ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_F));
   endfunction

   // Nibble value of a hex digit; meaningless when the byte is not a digit.
   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      logic [7:0] diff;
      diff = 8'd0;
      if ((b >= CHAR_ZERO) && (b <= CHAR_NINE)) begin
         diff = b - CHAR_ZERO;
         hex_nibble = diff[3:0];
      end else if ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_F)) begin
         diff = b - CHAR_LOWER_A;
         hex_nibble = diff[3:0] + HEX_LETTER_BASE;
      end else begin
         diff = b - CHAR_UPPER_A;
         hex_nibble = diff[3:0] + HEX_LETTER_BASE;
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/urlpd_front.sv */
// Front half of the URL percent decoder: tracks escapes and forms byte groups.
// Depends on urlpd_pkg.
`default_nettype none

module urlpd_front
   import urlpd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire logic [7:0]   in_byte,
   input  wire logic         in_last,
   input  wire logic         fifo_full,
   output logic              push,
   output group_type         push_group,
   output esc_mode_type      esc_mode
);

   esc_mode_type mode_ff, mode_in;
   logic [7:0]   held_ff, held_in;

   logic         accept;
   logic         is_hex;
   logic [3:0]   nibble;
   logic         ib_emit;
   logic         ib_start;
   logic [7:0]   ib_byte;
   esc_mode_type ib_mode;

   assign in_ready = !fifo_full;
   assign accept   = in_valid && in_ready;
   assign is_hex   = hex_valid(in_byte);
   assign nibble   = hex_nibble(in_byte);
   assign esc_mode = mode_ff;

   // How the byte is handled when no escape is pending.
   always_comb begin
      ib_emit  = 1'b1;
      ib_start = 1'b0;
      ib_byte  = in_byte;
      priority if (in_byte == CHAR_PLUS) begin
         ib_byte = CHAR_SPACE;
      end else if (in_byte == CHAR_PERCENT) begin
         ib_emit  = in_last;
         ib_start = !in_last;
      end else begin
         ib_byte = in_byte;
      end
      ib_mode = ib_start ? ESC_PCT : ESC_IDLE;
   end

   always_comb begin
      push_group       = '0;
      push_group.last  = in_last;
      mode_in          = mode_ff;
      held_in          = held_ff;
      unique case (mode_ff)
         ESC_PCT: begin
            if (is_hex && !in_last) begin
               held_in = in_byte;
               mode_in = ESC_DIGIT;
            end else begin
               push_group.bytes[0] = CHAR_PERCENT;
               push_group.bytes[1] = ib_byte;
               push_group.count    = ib_emit ? 2'd2 : 2'd1;
               mode_in             = ib_mode;
            end
         end
         ESC_DIGIT: begin
            if (is_hex) begin
               push_group.bytes[0] = {hex_nibble(held_ff), nibble};
               push_group.count    = 2'd1;
               mode_in             = ESC_IDLE;
            end else begin
               // Failed escape: flush the percent and the held digit literally.
               push_group.bytes[0] = CHAR_PERCENT;
               push_group.bytes[1] = held_ff;
               push_group.bytes[2] = ib_byte;
               push_group.count    = ib_emit ? 2'd3 : 2'd2;
               mode_in             = ib_mode;
            end
         end
         default: begin
            push_group.bytes[0] = ib_byte;
            push_group.count    = ib_emit ? 2'd1 : 2'd0;
            mode_in             = ib_mode;
         end
      endcase
      if (in_last) begin
         mode_in = ESC_IDLE;
      end
   end

   assign push = accept && (push_group.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ESC_IDLE;
         held_ff <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/urlpd_fifo.sv */
// Small queue of byte groups between the front and back halves of the decoder.
// Depends on urlpd_pkg for the group type.
`default_nettype none

module urlpd_fifo
   import urlpd_pkg::*;
#(
   parameter int unsigned DEPTH = FIFO_DEPTH_DEFAULT
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire group_type  push_data,
   input  wire logic       pop,
   output group_type       pop_data,
   output logic            full,
   output logic            empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   group_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/urlpd_back.sv */
// Back half of the URL percent decoder: walks each byte group into the output register.
// Depends on urlpd_pkg for the group type.
`default_nettype none

module urlpd_back
   import urlpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire group_type  head,
   input  wire logic       empty,
   output logic            pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [7:0]      out_byte,
   output logic            out_end_item,
   output logic            out_end_stream
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_item_ff, end_item_in;
   logic       end_stream_ff, end_stream_in;

   logic       load;
   logic       last_pos;

   assign load     = !empty && (!valid_ff || out_ready);
   assign last_pos = (idx_ff == (head.count - 2'd1));
   assign pop      = load && last_pos;

   always_comb begin
      unique case (idx_ff)
         2'd1:    byte_in = head.bytes[1];
         2'd2:    byte_in = head.bytes[2];
         default: byte_in = head.bytes[0];
      endcase
      end_item_in   = last_pos;
      end_stream_in = last_pos && head.last;
      idx_in        = idx_ff;
      valid_in      = valid_ff && !out_ready;
      if (load) begin
         idx_in   = last_pos ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= byte_in;
         end_item_ff   <= end_item_in;
         end_stream_ff <= end_stream_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_byte       = byte_ff;
   assign out_end_item   = end_item_ff;
   assign out_end_stream = end_stream_ff;

endmodule

`default_nettype wire

/* rtl/url_percent_decoder_core.sv */
// Top level of the streaming URL percent decoder.
// Depends on urlpd_pkg, urlpd_front, urlpd_fifo and urlpd_back.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+----------------------------------------
//   req     | in        | req_tvalid/tready  | tdata[7:0] encoded byte, tlast end of string
//   rsp     | out       | rsp_tvalid/tready  | tdata[7:0] decoded byte, tuser end of item,
//           |           |                    | tlast end of string
//
// An encoded byte is taken every cycle while the group queue has room. Each request
// transaction yields zero to three decoded bytes; the single output register sends one
// per cycle while rsp_tready is high, so a transaction that yields two or three bytes
// holds the output longer, and the queue of FIFO_DEPTH groups absorbs the difference.
// The first decoded byte passes through the group queue and then the output register.
// Synchronous reset clears the escape state, the queue and the output valid. A stall
// on rsp fills the queue and then drops req_tready; input stalls cost nothing.
`default_nettype none

module url_percent_decoder_core
   import urlpd_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] in_byte
   input  wire logic       req_tlast,    // in_last

   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] out_byte
   output logic [0:0]      rsp_tuser,    // [0] end_of_item
   output logic            rsp_tlast     // end_of_stream
);

   // Group handoff between the front half and the queue.
   logic         push;
   group_type    push_group;
   esc_mode_type esc_mode;

   // Queue head as seen by the back half.
   group_type    head;
   logic         pop;
   logic         fifo_full;
   logic         fifo_empty;
   logic         end_item;

   // The front half classifies each encoded byte and builds its group of output bytes.
   urlpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_group (push_group),
      .esc_mode   (esc_mode)
   );

   // Groups that carry no bytes are never queued.
   urlpd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_group),
      .pop       (pop),
      .pop_data  (head),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   // The back half sends one byte of the head group per cycle while rsp_tready is high.
   urlpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (fifo_empty),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_byte       (rsp_tdata),
      .out_end_item   (end_item),
      .out_end_stream (rsp_tlast)
   );

   assign rsp_tuser = end_item;

   // The end of a string always closes the current item as well.
   a_stream_end_closes_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("end of stream without end of item");

   // The front half only offers a group when the queue has room for it.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("group pushed into a full queue");

   // The back half only retires a group that is present.
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_empty)
      else $error("group popped from an empty queue");

   // A final byte always leaves no escape pending.
   a_last_clears_escape: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> esc_mode == ESC_IDLE)
      else $error("escape left pending after end of string");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for url_percent_decoder_core: a directed table, then random
// URL-encoded text under four idling phases, checked against an in-bench decoder.
// Depends on urlpd_pkg and the decoder RTL.

module tb_top;
   import urlpd_pkg::*;

   localparam int STUCK_LIMIT      = 3000;
   localparam int RANDOM_PER_PHASE = 64;
   localparam int NUM_PHASES       = 4;
   localparam int DRAIN_CYCLES     = 8;
   localparam int LAST_PCT         = 6;

   // Percent chance per cycle that the sender holds back or the receiver stalls.
   localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 87, 0, 18};
   localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 87, 18};

   // Value that digit_value returns for a byte that is not a hex digit.
   localparam logic [4:0] NOT_HEX = 5'd16;

   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   // One decoded byte as it should leave on the rsp channel.
   typedef struct packed {
      logic [7:0] data;
      logic       item_end;
      logic       stream_end;
   } beat_type;

   // All decoded bytes caused by one request transaction, oldest in bytes[0].
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
   } decoded_type;

   // A directed stimulus row. Rows marked TYPED carry their decoded bytes; the rest
   // are left to the behavioral decoder.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       typed;
      logic [1:0] n_out;
      logic [7:0] out0;
      logic [7:0] out1;
      logic [7:0] out2;
   } row_type;

   localparam int NUM_ROWS = 26;
   localparam row_type PLAN [NUM_ROWS] = '{
      // Plain bytes straight after reset, including both byte extremes.
      '{"A",          1'b0, TYPED,     2'd1, "A",          8'h00,        8'h00},
      '{CHAR_PLUS,    1'b0, TYPED,     2'd1, CHAR_SPACE,   8'h00,        8'h00},
      '{8'h00,        1'b0, TYPED,     2'd1, 8'h00,        8'h00,        8'h00},
      '{8'hFF,        1'b0, TYPED,     2'd1, 8'hFF,        8'h00,        8'h00},
      // Escapes that decode to the largest and the smallest byte; the percent and the
      // first digit give nothing on their own.
      '{CHAR_PERCENT, 1'b0, TYPED,     2'd0, 8'h00,        8'h00,        8'h00},
      '{"f",          1'b0, TYPED,     2'd0, 8'h00,        8'h00,        8'h00},
      '{"F",          1'b0, TYPED,     2'd1, 8'hFF,        8'h00,        8'h00},
      '{CHAR_PERCENT, 1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{"0",          1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{"0",          1'b0, TYPED,     2'd1, 8'h00,        8'h00,        8'h00},
      // A bad first digit flushes the percent and passes the byte through.
      '{CHAR_PERCENT, 1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{"g",          1'b0, TYPED,     2'd2, CHAR_PERCENT, "g",          8'h00},
      // A percent as the bad second digit flushes and then opens a new escape.
      '{CHAR_PERCENT, 1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{"a",          1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{CHAR_PERCENT, 1'b0, TYPED,     2'd2, CHAR_PERCENT, "a",          8'h00},
      '{"9",          1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{CHAR_PLUS,    1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      // End of string right after a percent, where the last byte is a percent too.
      '{CHAR_PERCENT, 1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{CHAR_PERCENT, 1'b1, TYPED,     2'd2, CHAR_PERCENT, CHAR_PERCENT, 8'h00},
      '{CHAR_PERCENT, 1'b1, TYPED,     2'd1, CHAR_PERCENT, 8'h00,        8'h00},
      // End of string on a bad second digit gives three bytes.
      '{CHAR_PERCENT, 1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{"7",          1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{"z",          1'b1, TYPED,     2'd3, CHAR_PERCENT, "7",          "z"},
      // End of string on a good second digit, mixed case.
      '{CHAR_PERCENT, 1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{"B",          1'b0, PREDICTED, 2'd0, 8'h00,        8'h00,        8'h00},
      '{"c",          1'b1, TYPED,     2'd1, 8'hBC,        8'h00,        8'h00}
   };

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic       rsp_tlast;

   // Escape state of the behavioral decoder.
   esc_mode_type dec_mode;
   logic [7:0]   dec_held;

   beat_type expected_beats[$];
   beat_type want;
   int       mismatches;
   int       stuck_cycles;
   int       random_sent;
   int       send_idle_pct;
   int       recv_stall_pct;

   url_percent_decoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] in_byte
      .req_tlast  (req_tlast),    // in_last
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] out_byte
      .rsp_tuser  (rsp_tuser),    // [0] end_of_item
      .rsp_tlast  (rsp_tlast)     // end_of_stream
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hex value of a character, or NOT_HEX.
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         t = c - CHAR_ZERO;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         t = c - CHAR_LOWER_A + 8'd10;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         t = c - CHAR_UPPER_A + 8'd10;
      end else begin
         return NOT_HEX;
      end
      return {1'b0, t[3:0]};
   endfunction

   function automatic decoded_type append_byte(input decoded_type d, input logic [7:0] b);
      d.bytes[d.count] = b;
      d.count = d.count + 2'd1;
      return d;
   endfunction

   // A byte seen with no escape pending. A percent that is not last opens an escape.
   function automatic decoded_type plain_byte(input decoded_type d, input logic [7:0] b,
                                              input logic l);
      if (b == CHAR_PLUS) begin
         d = append_byte(d, CHAR_SPACE);
      end else if (b == CHAR_PERCENT && !l) begin
         dec_mode = ESC_PCT;
      end else begin
         d = append_byte(d, b);
      end
      return d;
   endfunction

   // Advances the decoder by one encoded byte and returns the bytes it gives.
   function automatic decoded_type decode_step(input logic [7:0] b, input logic l);
      decoded_type  d;
      esc_mode_type mode;
      logic [4:0]   lo;
      logic [4:0]   hi;
      d    = '0;
      mode = dec_mode;
      lo   = digit_value(b);
      dec_mode = ESC_IDLE;
      case (mode)
         ESC_PCT: begin
            if (lo != NOT_HEX && !l) begin
               dec_held = b;
               dec_mode = ESC_DIGIT;
            end else begin
               d = append_byte(d, CHAR_PERCENT);
               d = plain_byte(d, b, l);
            end
         end
         ESC_DIGIT: begin
            if (lo != NOT_HEX) begin
               hi = digit_value(dec_held);
               d  = append_byte(d, {hi[3:0], lo[3:0]});
            end else begin
               d = append_byte(d, CHAR_PERCENT);
               d = append_byte(d, dec_held);
               d = plain_byte(d, b, l);
            end
         end
         default: begin
            d = plain_byte(d, b, l);
         end
      endcase
      if (l) begin
         dec_mode = ESC_IDLE;
      end
      return d;
   endfunction

   // Drives one request transaction at the falling edge, waits for it to be taken and
   // queues the decoded bytes it should cause.
   task automatic send_item(input logic [7:0] b, input logic l, input logic typed,
                            input decoded_type typed_out);
      decoded_type d;
      beat_type    beat;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      d = decode_step(b, l);
      if (typed) begin
         d = typed_out;
      end
      for (int i = 0; i < d.count; i++) begin
         beat.data       = d.bytes[i];
         beat.item_end   = (i == d.count - 1);
         beat.stream_end = (i == d.count - 1) && l;
         expected_beats.push_back(beat);
      end
      @(negedge clock);
   endtask

   task automatic send_random_byte(input logic [7:0] b);
      send_item(b, ($urandom_range(99) < LAST_PCT), PREDICTED, '0);
      random_sent++;
   endtask

   function automatic logic [7:0] random_hex_char();
      logic [3:0] n;
      n = 4'($urandom_range(15));
      if (n < 4'd10) begin
         return CHAR_ZERO + {4'd0, n};
      end
      return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'd0, n - 4'd10};
   endfunction

   // A byte that ends an escape badly; now and then a percent or a plus.
   function automatic logic [7:0] random_non_hex_char();
      logic [7:0] c;
      if ($urandom_range(3) == 0) begin
         return $urandom_range(1) ? CHAR_PERCENT : CHAR_PLUS;
      end
      do begin
         c = 8'($urandom_range(255));
      end while (digit_value(c) != NOT_HEX);
      return c;
   endfunction

   // Nearly half are well-formed escapes with random digits; the rest are plus signs, broken
   // escapes and arbitrary bytes.
   task automatic send_random_token();
      int kind;
      kind = $urandom_range(99);
      if (kind < 45) begin
         send_random_byte(CHAR_PERCENT);
         send_random_byte(random_hex_char());
         send_random_byte(random_hex_char());
      end else if (kind < 55) begin
         send_random_byte(CHAR_PLUS);
      end else if (kind < 68) begin
         send_random_byte(CHAR_PERCENT);
         if ($urandom_range(1)) begin
            send_random_byte(random_hex_char());
         end
         send_random_byte(random_non_hex_char());
      end else begin
         send_random_byte(8'($urandom_range(255)));
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Each rsp transaction is compared with the oldest expected byte.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: expected no decoded byte, got data %h end_of_item %b end_of_stream %b",
                     $time, rsp_tdata, rsp_tuser[0], rsp_tlast);
            mismatches++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tdata !== want.data) begin
               $display("%0t: data expected %h, got %h", $time, want.data, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser[0] !== want.item_end) begin
               $display("%0t: end_of_item expected %b, got %b", $time, want.item_end,
                        rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tlast !== want.stream_end) begin
               $display("%0t: end_of_stream expected %b, got %b", $time, want.stream_end,
                        rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // The run is stuck when no transaction happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      req_tlast      = 1'b0;
      dec_mode       = ESC_IDLE;
      dec_held       = 8'h00;
      random_sent    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_item(PLAN[i].code, PLAN[i].last, PLAN[i].typed,
                   '{count: PLAN[i].n_out,
                     bytes: {PLAN[i].out2, PLAN[i].out1, PLAN[i].out0}});
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct  = SEND_IDLE_PCT[p];
         recv_stall_pct = RECV_STALL_PCT[p];
         while (random_sent < (p + 1) * RANDOM_PER_PHASE) begin
            send_random_token();
         end
      end

      // Drain with the receiver always ready, then keep watching for
      // stray output.
      req_tvalid <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (expected_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
